[sv/bset_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bset_pkg
// Shared types, constants and helper functions of the Burning Ship escape-time
// core: fixed-point widths, register defaults, sequencer states and saturation.
// ----------------------------------------------------------------------------
package bset_pkg;

    // Field and datapath widths
    localparam int PIX_W    = 9;
    localparam int CFG_W    = 32;
    localparam int SPAN_W   = 31;
    localparam int LIMIT_W  = 16;
    localparam int CNT_W    = 16;
    localparam int Q_W      = 48;   // signed Q16.32
    localparam int MAG_W    = 47;   // magnitude of a Q16.32 value
    localparam int WIDE_W   = 50;   // headroom for sums before saturation
    localparam int PROD_W   = 94;   // full product of two magnitudes
    localparam int HALF_LO  = 24;   // low slice of a magnitude
    localparam int HALF_HI  = MAG_W - HALF_LO;
    localparam int PP_W     = 2 * HALF_LO;
    localparam int FRAC_W   = 32;
    localparam int STEP_W   = 3;
    localparam int IMAGE_SIDE_DEF = 512;

    // Register defaults, also used in place of a zero value
    localparam logic [SPAN_W-1:0]  DEFAULT_SPAN  = 31'd5368709;   // 0.02 in Q3.28
    localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = 16'd1000;

    // Escape threshold 256.0 in Q16.32
    localparam logic [Q_W-1:0] ESCAPE_R2 = 48'h0100_0000_0000;

    localparam logic signed [Q_W-1:0]    Q_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [Q_W-1:0]    Q_MIN = 48'sh8000_0000_0000;
    localparam logic signed [WIDE_W-1:0] W_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [WIDE_W-1:0] W_MIN = 50'sh3_8000_0000_0000;
    localparam logic [MAG_W-1:0]         MAG_MAX = 47'h7FFF_FFFF_FFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CENTER_REAL = 2'd0,
        CFG_CENTER_IMAG = 2'd1,
        CFG_VIEW_SPAN   = 2'd2,
        CFG_ITER_LIMIT  = 2'd3
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CR_MUL,
        S_CI_MUL,
        S_C_ADD,
        S_X_GO,
        S_X_WAIT,
        S_UPDATE,
        S_R_GO,
        S_R_WAIT,
        S_I_GO,
        S_I_WAIT,
        S_CHECK,
        S_OUT
    } bset_state_t;

    // Status of the shared multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;

    // Clamp a wide signed sum to the Q16.32 range
    function automatic logic signed [Q_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        priority if (v > W_MAX)
            r = Q_MAX;
        else if (v < W_MIN)
            r = Q_MIN;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    // Magnitude of a Q16.32 value; the most negative value clamps to the maximum
    function automatic logic [MAG_W-1:0] mag48(input logic signed [Q_W-1:0] v);
        logic signed [Q_W-1:0] n;
        logic [MAG_W-1:0]      r;
        n = -v;
        priority if (!v[Q_W-1])
            r = v[MAG_W-1:0];
        else if (v == Q_MIN)
            r = MAG_MAX;
        else
            r = n[MAG_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/bset_mulq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bset_mulq
// Multi-cycle multiplier of two 47-bit magnitudes. One 24x24 partial product a
// cycle, registered, then accumulated; the result is the product truncated to
// Q16.32 and clamped to the largest positive value.
// ----------------------------------------------------------------------------
module bset_mulq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bset_pkg::MAG_W-1:0]  opa,
    input  wire logic [bset_pkg::MAG_W-1:0]  opb,
    output logic      [bset_pkg::MAG_W-1:0]  result,
    output bset_pkg::mul_sts_t               sts
);

    localparam logic [bset_pkg::STEP_W-1:0] LAST_STEP = 3'd4;

    logic                            busy_reg;
    logic                            done_reg;
    logic [bset_pkg::STEP_W-1:0]     step_reg;
    logic [1:0]                      phase_reg;
    logic [bset_pkg::PP_W-1:0]       pp_reg;
    logic [bset_pkg::PROD_W-1:0]     acc_reg;

    logic [bset_pkg::HALF_LO-1:0]    a_lo;
    logic [bset_pkg::HALF_LO-1:0]    a_hi;
    logic [bset_pkg::HALF_LO-1:0]    b_lo;
    logic [bset_pkg::HALF_LO-1:0]    b_hi;
    logic [bset_pkg::HALF_LO-1:0]    mx;
    logic [bset_pkg::HALF_LO-1:0]    my;
    logic [bset_pkg::PP_W-1:0]       pp_next;
    logic [bset_pkg::PROD_W-1:0]     pp_shifted;
    logic [bset_pkg::PROD_W-1:0]     acc_next;
    logic                            overflow;

    // Split operands into a low and a high slice
    assign a_lo = opa[bset_pkg::HALF_LO-1:0];
    assign b_lo = opb[bset_pkg::HALF_LO-1:0];
    assign a_hi = {1'b0, opa[bset_pkg::MAG_W-1:bset_pkg::HALF_LO]};
    assign b_hi = {1'b0, opb[bset_pkg::MAG_W-1:bset_pkg::HALF_LO]};

    // Pick the slices of this step and form the partial product
    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:
            begin
                mx = a_lo;
                my = b_lo;
            end
            2'd1:
            begin
                mx = a_hi;
                my = b_lo;
            end
            2'd2:
            begin
                mx = a_lo;
                my = b_hi;
            end
            default:
            begin
                mx = a_hi;
                my = b_hi;
            end
        endcase
        pp_next = mx * my;
    end

    // Align the registered partial product and add it in
    always_comb
    begin
        unique case (phase_reg)
            2'd0:    pp_shifted = bset_pkg::PROD_W'(pp_reg);
            2'd1:    pp_shifted = bset_pkg::PROD_W'(pp_reg) << bset_pkg::HALF_LO;
            2'd2:    pp_shifted = bset_pkg::PROD_W'(pp_reg) << bset_pkg::HALF_LO;
            default: pp_shifted = bset_pkg::PROD_W'(pp_reg) << (2 * bset_pkg::HALF_LO);
        endcase
        acc_next = acc_reg + pp_shifted;
    end

    // Truncate to Q16.32 and clamp
    assign overflow = |acc_reg[bset_pkg::PROD_W-1:bset_pkg::FRAC_W+bset_pkg::MAG_W];
    assign result   = overflow ? bset_pkg::MAG_MAX
                               : acc_reg[bset_pkg::FRAC_W+bset_pkg::MAG_W-1:bset_pkg::FRAC_W];

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 3'd1;
            done_reg <= (step_reg == LAST_STEP);
            if (step_reg == LAST_STEP)
                busy_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Partial product register and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != '0)
                acc_reg <= acc_next;
            if (step_reg != LAST_STEP)
            begin
                pp_reg    <= pp_next;
                phase_reg <= step_reg[1:0];
            end
        end
    end

    // Checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held for more than one cycle");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && step_reg == '0))
        else $error("multiplier did not restart on request");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("multiplier done without a running product");

endmodule
`default_nettype wire

[sv/burning_ship_escape_time_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// burning_ship_escape_time_core
// Escape-time evaluator for the Burning Ship fractal in saturating Q16.32.
//
// Usage:
//   Input stream (s_axis_*): one request per pixel, carrying column and row.
//   Output stream (m_axis_*): one result per request: iteration count, inside
//   flag and the last z.
//   Configuration (cfg_*): view center, view span and iteration limit, written
//   while the core holds no request. Zero span and zero limit select defaults.
//   One request is worked on at a time; s_axis_tready is high only when idle.
//   Sequence: c is formed in S_CR_MUL, S_CI_MUL and S_C_ADD, then the
//   iterations run, then the result stands on the output in S_OUT.
//   Each iteration runs three 47x47 products through one shared 24x24
//   multiplier plus one update state and one escape check state.
//   A stalled receiver holds the result and the core accepts nothing new.
//   Reset restores the register defaults (center 0, span 0.02, limit 1000)
//   and leaves the core idle.
// ----------------------------------------------------------------------------
module burning_ship_escape_time_core #(
    parameter int IMAGE_SIDE = bset_pkg::IMAGE_SIDE_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // Configuration write port
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    // Pixel requests
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [23:0]   s_axis_tdata,   // [8:0] pixel_x, [17:9] pixel_y, zero pad
    // Results
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [119:0]       m_axis_tdata    // [15:0] iteration_count, [16] inside_set,
                                               // [64:17] final_real, [112:65] final_imag,
                                               // zero pad
);

    localparam int SIDE_LOG2 = $clog2(IMAGE_SIDE);
    localparam int SPROD_W   = bset_pkg::PIX_W + bset_pkg::SPAN_W;

    // Configuration registers
    logic signed [bset_pkg::CFG_W-1:0]   center_real_reg;
    logic signed [bset_pkg::CFG_W-1:0]   center_imag_reg;
    logic        [bset_pkg::SPAN_W-1:0]  view_span_reg;
    logic        [bset_pkg::LIMIT_W-1:0] iteration_limit_reg;

    bset_pkg::bset_state_t state_reg;
    bset_pkg::bset_state_t state_next;

    // Datapath registers
    logic        [bset_pkg::PIX_W-1:0]   px_reg;
    logic        [bset_pkg::PIX_W-1:0]   py_reg;
    logic        [SPROD_W-1:0]           prod_reg;
    logic signed [bset_pkg::Q_W-1:0]     cr_reg;
    logic signed [bset_pkg::Q_W-1:0]     ci_reg;
    logic signed [bset_pkg::Q_W-1:0]     zr_reg;
    logic signed [bset_pkg::Q_W-1:0]     zi_reg;
    logic        [bset_pkg::MAG_W-1:0]   ar_reg;
    logic        [bset_pkg::MAG_W-1:0]   ai_reg;
    logic        [bset_pkg::MAG_W-1:0]   sr_reg;
    logic        [bset_pkg::MAG_W-1:0]   si_reg;
    logic        [bset_pkg::CNT_W-1:0]   iter_reg;
    logic                                inside_reg;

    // Combinational signals
    logic        [bset_pkg::SPAN_W-1:0]  span_eff;
    logic        [bset_pkg::LIMIT_W-1:0] limit_eff;
    logic        [bset_pkg::PIX_W-1:0]   pix_sel;
    logic        [SPROD_W-1:0]           prod_next;
    logic signed [bset_pkg::CFG_W-1:0]   center_sel;
    logic signed [bset_pkg::WIDE_W-1:0]  corner_w;
    logic signed [bset_pkg::WIDE_W-1:0]  offset_w;
    logic signed [bset_pkg::Q_W-1:0]     c_next;
    logic signed [bset_pkg::Q_W-1:0]     nr;
    logic signed [bset_pkg::Q_W-1:0]     ni;
    logic        [bset_pkg::Q_W-1:0]     r2;
    logic        [bset_pkg::CNT_W:0]     iter_plus;
    logic                                escape;
    logic                                at_limit;
    logic                                in_accept;

    // Shared multiplier
    logic                                mul_start;
    logic        [bset_pkg::MAG_W-1:0]   mul_a;
    logic        [bset_pkg::MAG_W-1:0]   mul_b;
    logic        [bset_pkg::MAG_W-1:0]   mul_result;
    bset_pkg::mul_sts_t                  mul_sts;

    bset_mulq u_mulq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .opa    (mul_a),
        .opb    (mul_b),
        .result (mul_result),
        .sts    (mul_sts)
    );

    // Zero span and zero limit fall back to the defaults
    assign span_eff  = (view_span_reg == '0) ? bset_pkg::DEFAULT_SPAN : view_span_reg;
    assign limit_eff = (iteration_limit_reg == '0) ? bset_pkg::DEFAULT_LIMIT
                                                   : iteration_limit_reg;

    // Form c: corner plus index times span over the image side
    assign pix_sel    = (state_reg == bset_pkg::S_CR_MUL) ? px_reg : py_reg;
    assign prod_next  = SPROD_W'(pix_sel) * SPROD_W'(span_eff);
    assign center_sel = (state_reg == bset_pkg::S_CI_MUL) ? center_real_reg : center_imag_reg;
    assign corner_w   = (bset_pkg::WIDE_W'(center_sel) <<< 4)
                      - $signed({{(bset_pkg::WIDE_W-bset_pkg::SPAN_W-3){1'b0}}, span_eff, 3'b000});
    assign offset_w   = $signed((bset_pkg::WIDE_W'(prod_reg) << 4) >> SIDE_LOG2);
    assign c_next     = bset_pkg::sat48(corner_w + offset_w);

    // New z from the cached squares and the cross product
    assign nr = bset_pkg::sat48($signed({3'b000, sr_reg}) - $signed({3'b000, si_reg})
                                + bset_pkg::WIDE_W'(cr_reg));
    assign ni = bset_pkg::sat48($signed({2'b00, mul_result, 1'b0})
                                + bset_pkg::WIDE_W'(ci_reg));

    // Escape test and iteration count
    assign r2        = {1'b0, sr_reg} + {1'b0, si_reg};
    assign escape    = (r2 > bset_pkg::ESCAPE_R2);
    assign iter_plus = {1'b0, iter_reg} + 17'd1;
    assign at_limit  = (iter_plus >= {1'b0, limit_eff});
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bset_pkg::S_IDLE:   if (s_axis_tvalid) state_next = bset_pkg::S_CR_MUL;
            bset_pkg::S_CR_MUL: state_next = bset_pkg::S_CI_MUL;
            bset_pkg::S_CI_MUL: state_next = bset_pkg::S_C_ADD;
            bset_pkg::S_C_ADD:  state_next = bset_pkg::S_X_GO;
            bset_pkg::S_X_GO:   state_next = bset_pkg::S_X_WAIT;
            bset_pkg::S_X_WAIT: if (mul_sts.done) state_next = bset_pkg::S_UPDATE;
            bset_pkg::S_UPDATE: state_next = bset_pkg::S_R_GO;
            bset_pkg::S_R_GO:   state_next = bset_pkg::S_R_WAIT;
            bset_pkg::S_R_WAIT: if (mul_sts.done) state_next = bset_pkg::S_I_GO;
            bset_pkg::S_I_GO:   state_next = bset_pkg::S_I_WAIT;
            bset_pkg::S_I_WAIT: if (mul_sts.done) state_next = bset_pkg::S_CHECK;
            bset_pkg::S_CHECK:  state_next = (escape || at_limit) ? bset_pkg::S_OUT
                                                                  : bset_pkg::S_X_GO;
            bset_pkg::S_OUT:    if (m_axis_tready) state_next = bset_pkg::S_IDLE;
            default:            state_next = bset_pkg::S_IDLE;
        endcase
    end

    // Outputs and multiplier operand selection
    always_comb
    begin
        s_axis_tready = (state_reg == bset_pkg::S_IDLE);
        m_axis_tvalid = (state_reg == bset_pkg::S_OUT);
        mul_start     = (state_reg == bset_pkg::S_X_GO) || (state_reg == bset_pkg::S_R_GO)
                     || (state_reg == bset_pkg::S_I_GO);
        unique case (state_reg)
            bset_pkg::S_R_GO, bset_pkg::S_R_WAIT:
            begin
                mul_a = ar_reg;
                mul_b = ar_reg;
            end
            bset_pkg::S_I_GO, bset_pkg::S_I_WAIT:
            begin
                mul_a = ai_reg;
                mul_b = ai_reg;
            end
            default:
            begin
                mul_a = ar_reg;
                mul_b = ai_reg;
            end
        endcase
    end

    assign m_axis_tdata = {7'd0, zi_reg, zr_reg, inside_reg, iter_reg};

    // Configuration registers and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= bset_pkg::S_IDLE;
            center_real_reg     <= '0;
            center_imag_reg     <= '0;
            view_span_reg       <= bset_pkg::DEFAULT_SPAN;
            iteration_limit_reg <= bset_pkg::DEFAULT_LIMIT;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (bset_pkg::cfg_index_t'(cfg_index))
                    bset_pkg::CFG_CENTER_REAL: center_real_reg     <= $signed(cfg_data);
                    bset_pkg::CFG_CENTER_IMAG: center_imag_reg     <= $signed(cfg_data);
                    bset_pkg::CFG_VIEW_SPAN:   view_span_reg       <= cfg_data[bset_pkg::SPAN_W-1:0];
                    bset_pkg::CFG_ITER_LIMIT:  iteration_limit_reg <= cfg_data[bset_pkg::LIMIT_W-1:0];
                    default:                   view_span_reg       <= view_span_reg;
                endcase
            end
        end
    end

    // Datapath: latch the request, form c, iterate, count
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            bset_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    px_reg   <= s_axis_tdata[bset_pkg::PIX_W-1:0];
                    py_reg   <= s_axis_tdata[2*bset_pkg::PIX_W-1:bset_pkg::PIX_W];
                    zr_reg   <= '0;
                    zi_reg   <= '0;
                    ar_reg   <= '0;
                    ai_reg   <= '0;
                    sr_reg   <= '0;
                    si_reg   <= '0;
                    iter_reg <= '0;
                end
            end
            bset_pkg::S_CR_MUL:
            begin
                prod_reg <= prod_next;
            end
            bset_pkg::S_CI_MUL:
            begin
                cr_reg   <= c_next;
                prod_reg <= prod_next;
            end
            bset_pkg::S_C_ADD:
            begin
                ci_reg <= c_next;
            end
            bset_pkg::S_UPDATE:
            begin
                zr_reg <= nr;
                zi_reg <= ni;
                ar_reg <= bset_pkg::mag48(nr);
                ai_reg <= bset_pkg::mag48(ni);
            end
            bset_pkg::S_R_WAIT:
            begin
                if (mul_sts.done)
                    sr_reg <= mul_result;
            end
            bset_pkg::S_I_WAIT:
            begin
                if (mul_sts.done)
                    si_reg <= mul_result;
            end
            bset_pkg::S_CHECK:
            begin
                if (escape)
                begin
                    inside_reg <= 1'b0;
                end
                else
                begin
                    iter_reg   <= iter_plus[bset_pkg::CNT_W-1:0];
                    inside_reg <= at_limit;
                end
            end
            default:
            begin
                iter_reg <= iter_reg;
            end
        endcase
    end

    // Checks
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while a result is pending");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_sts.busy)
        else $error("multiplier started while busy");

    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_sts.done |-> (state_reg == bset_pkg::S_X_WAIT || state_reg == bset_pkg::S_R_WAIT
                          || state_reg == bset_pkg::S_I_WAIT))
        else $error("multiplier finished outside a wait state");

    a_inside_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && inside_reg) |-> (iter_reg == limit_eff))
        else $error("inside flag without reaching the iteration limit");

endmodule
`default_nettype wire

[sim/burning_ship_escape_time_core_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// burning_ship_escape_time_core_tb
// Self-checking bench for the Burning Ship escape-time core. Pixel requests go
// in over the input stream, and a local saturating Q16.32 predictor works out
// each escape count, inside flag and final z. Every result on the output stream
// is compared field by field with the oldest prediction. The run covers default
// and extreme views, zero span and zero limit, and then random views under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module burning_ship_escape_time_core_tb;

    localparam int     IMAGE_SIDE      = 512;
    localparam int     VIEWS_PER_PHASE = 5;
    localparam int     PIXELS_PER_VIEW = 30;
    localparam int     SETTLE_CYCLES   = 30;
    localparam int     CYCLE_LIMIT     = 4_000_000;

    localparam longint Q_TOP        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q_BOT        = -64'sh0000_8000_0000_0000;
    localparam longint ESCAPE_LEVEL = 64'sh0000_0100_0000_0000;   // 256.0

    // Fields of one result
    typedef struct packed {
        logic [15:0] count;
        logic        in_set;
        logic [47:0] z_re;
        logic [47:0] z_im;
    } escape_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    bset_pkg::cfg_index_t cfg_index = bset_pkg::CFG_CENTER_REAL;
    logic [31:0]          cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;      // [8:0] pixel_x, [17:9] pixel_y, zero pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [119:0]         m_axis_tdata;           // [15:0] iteration_count, [16] inside_set,
                                                  // [64:17] final_real, [112:65] final_imag

    // Local copy of the view registers
    longint         centre_re;
    longint         centre_im;
    logic [30:0]    span_reg;
    logic [15:0]    limit_reg;

    escape_t        escape_queue[$];
    int             src_idle_pct;
    int             sink_stall_pct;
    int             errors;
    int             requests_sent;
    int             results_checked;
    int             inside_seen;
    int             views_loaded;
    int             cycle_count;

    burning_ship_escape_time_core #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic longint clamp_q(input longint v);
        if (v > Q_TOP)
            return Q_TOP;
        if (v < Q_BOT)
            return Q_BOT;
        return v;
    endfunction

    // Magnitude; the most negative value clamps to the top of the range
    function automatic longint abs_q(input longint v);
        if (v >= 0)
            return v;
        if (v == Q_BOT)
            return Q_TOP;
        return -v;
    endfunction

    // Product of two magnitudes, truncated to Q16.32 and clamped
    function automatic longint mul_mag(input longint a, input longint b);
        logic [127:0] wa;
        logic [127:0] wb;
        logic [127:0] p;
        wa = a;
        wb = b;
        p  = (wa * wb) >> 32;
        if (p > Q_TOP)
            return Q_TOP;
        return longint'(p[63:0]);
    endfunction

    // Corner of the view plus the pixel's share of the span, in Q16.32
    function automatic longint view_coord(input longint centre, input longint span,
                                          input longint idx);
        longint corner;
        longint step;
        corner = centre * 16 - span * 8;
        step   = (idx * span * 16) / IMAGE_SIDE;
        return clamp_q(corner + step);
    endfunction

    function automatic escape_t predict_escape(input logic [8:0] px, input logic [8:0] py);
        longint  span;
        longint  cr;
        longint  ci;
        longint  zr;
        longint  zi;
        longint  ar;
        longint  ai;
        longint  nr;
        longint  ni;
        longint  r2;
        int      lim;
        int      iter;
        logic    escaped;
        escape_t res;
        span    = (span_reg == '0) ? longint'(bset_pkg::DEFAULT_SPAN) : longint'(span_reg);
        lim     = (limit_reg == '0) ? int'(bset_pkg::DEFAULT_LIMIT) : int'(limit_reg);
        cr      = view_coord(centre_re, span, longint'(px));
        ci      = view_coord(centre_im, span, longint'(py));
        zr      = 0;
        zi      = 0;
        iter    = 0;
        escaped = 1'b0;
        while (!escaped && iter < lim)
        begin
            ar = abs_q(zr);
            ai = abs_q(zi);
            nr = clamp_q(mul_mag(ar, ar) - mul_mag(ai, ai) + cr);
            ni = clamp_q(2 * mul_mag(ar, ai) + ci);
            zr = nr;
            zi = ni;
            ar = abs_q(zr);
            ai = abs_q(zi);
            r2 = clamp_q(mul_mag(ar, ar) + mul_mag(ai, ai));
            if (r2 > ESCAPE_LEVEL)
                escaped = 1'b1;
            else
                iter++;
        end
        res.count  = iter[15:0];
        res.in_set = (iter >= lim);
        res.z_re   = zr[47:0];
        res.z_im   = zi[47:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------------

    // Write all four view registers on consecutive cycles; call only while idle
    task automatic load_view(input logic [31:0] re, input logic [31:0] im,
                             input logic [31:0] span, input logic [31:0] lim);
        cfg_write <= 1'b1;
        cfg_index <= bset_pkg::CFG_CENTER_REAL;
        cfg_data  <= re;
        @(posedge clk);
        cfg_index <= bset_pkg::CFG_CENTER_IMAG;
        cfg_data  <= im;
        @(posedge clk);
        cfg_index <= bset_pkg::CFG_VIEW_SPAN;
        cfg_data  <= span;
        @(posedge clk);
        cfg_index <= bset_pkg::CFG_ITER_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_write <= 1'b0;
        centre_re = $signed(re);
        centre_im = $signed(im);
        span_reg  = span[30:0];
        limit_reg = lim[15:0];
        views_loaded++;
    endtask

    // Offer one pixel request, with a random gap first, and hold until taken
    task automatic send_pixel(input logic [8:0] px, input logic [8:0] py);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, py, px};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        escape_queue.push_back(predict_escape(px, py));
        requests_sent++;
    endtask

    // Drop the request line and wait for every outstanding result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (escape_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : result_check
        escape_t want;
        escape_t got;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.count  = m_axis_tdata[15:0];
                got.in_set = m_axis_tdata[16];
                got.z_re   = m_axis_tdata[64:17];
                got.z_im   = m_axis_tdata[112:65];
                results_checked++;
                if (got.in_set)
                    inside_seen++;
                if (escape_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing pending: %h", $time, got);
                end
                else
                begin
                    want = escape_queue.pop_front();
                    if (got.count !== want.count)
                    begin
                        errors++;
                        $display("%0t: iteration_count expected %0d got %0d",
                                 $time, want.count, got.count);
                    end
                    if (got.in_set !== want.in_set)
                    begin
                        errors++;
                        $display("%0t: inside_set expected %0d got %0d",
                                 $time, want.in_set, got.in_set);
                    end
                    if (got.z_re !== want.z_re)
                    begin
                        errors++;
                        $display("%0t: final_real expected %h got %h",
                                 $time, want.z_re, got.z_re);
                    end
                    if (got.z_im !== want.z_im)
                    begin
                        errors++;
                        $display("%0t: final_imag expected %h got %h",
                                 $time, want.z_im, got.z_im);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Hard stop if the core hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, escape_queue.size());
            $display("burning_ship_escape_time_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset view: centre 0, span 0.02, limit 1000, so both points stay inside
    task automatic test_defaults();
        centre_re = 0;
        centre_im = 0;
        span_reg  = bset_pkg::DEFAULT_SPAN;
        limit_reg = bset_pkg::DEFAULT_LIMIT;
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        wait_drained();
    endtask

    // Wide view of 4.0 around (-0.5, -0.5), corner and middle pixels
    task automatic test_wide_view();
        load_view(32'hF800_0000, 32'hF800_0000, 32'h4000_0000, 32'd30);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd511);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd170, 9'd341);
        wait_drained();
    endtask

    // A zero span falls back to 0.02
    task automatic test_zero_span();
        load_view(32'hE400_0000, 32'hFF5C_28F6, 32'h8000_0000, 32'd25);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        wait_drained();
    endtask

    // A zero limit falls back to 1000: one quick escape, one point inside
    task automatic test_zero_limit();
        load_view(32'h0000_0000, 32'h0000_0000, 32'h4000_0000, 32'hFFFF_0000);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd256, 9'd256);
        wait_drained();
    endtask

    // Centres at the ends of the range, largest and smallest span, top limit
    task automatic test_extreme_views();
        load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF);
        send_pixel(9'd0, 9'd511);
        send_pixel(9'd511, 9'd0);
        wait_drained();
        load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_FFFF);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        wait_drained();
        load_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        wait_drained();
        load_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h8000_FFFF);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd0, 9'd511);
        wait_drained();
    endtask

    // Random views with short limits, random pixels, given gap and stall rates
    task automatic test_random_views(input int idle_pct, input int stall_pct);
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] span;
        logic [31:0] lim;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int v = 0; v < VIEWS_PER_PHASE; v++)
        begin
            // mostly the interesting region, now and then anywhere
            if ($urandom_range(3) == 0)
            begin
                re = $urandom;
                im = $urandom;
            end
            else
            begin
                re = $urandom_range(805306368) - 32'd536870912;
                im = $urandom_range(805306368) - 32'd536870912;
            end
            case ($urandom_range(9))
                0:       span = {1'($urandom_range(1)), 31'd0};
                1, 2:    span = $urandom;
                default: span = {1'($urandom_range(1)), 31'($urandom_range(32'h4000_0000)
                                                            >> $urandom_range(22))};
            endcase
            lim = {16'($urandom), 16'($urandom_range(40, 1))};
            load_view(re, im, span, lim);
            for (int n = 0; n < PIXELS_PER_VIEW; n++)
                send_pixel(9'($urandom_range(511)), 9'($urandom_range(511)));
            wait_drained();
        end
    endtask

    initial
    begin
        errors          = 0;
        requests_sent   = 0;
        results_checked = 0;
        inside_seen     = 0;
        views_loaded    = 0;
        cycle_count     = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_defaults();
        test_wide_view();
        test_zero_span();
        test_zero_limit();
        test_extreme_views();
        test_random_views(0, 0);
        test_random_views(67, 0);
        test_random_views(0, 67);
        test_random_views(37, 37);

        $display("ran %0d pixel requests over %0d views, %0d results checked, %0d inside",
                 requests_sent, views_loaded, results_checked, inside_seen);
        $display("took %0d cycles with %0d errors", cycle_count, errors);
        if (errors == 0)
            $display("burning_ship_escape_time_core: match");
        else
            $display("burning_ship_escape_time_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
sv/bset_pkg.sv
sv/bset_mulq.sv
sv/burning_ship_escape_time_core.sv
sim/burning_ship_escape_time_core_tb.sv
